// ===== hdl/grt_pkg.sv =====
// Package for the guarded region table: types, codes and defaults.
package grt_pkg;

    localparam int MaxEntriesDefault = 16;
    localparam int PageShiftDefault  = 12;
    localparam int OffsetBitsDefault = 32;
    localparam logic [31:0] SpaceSizeReset = 32'd268435456;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_EXPAND = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOSPACE = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_OVERCAP = 3'd4;

    localparam logic [1:0] FK_NONE  = 2'd0;
    localparam logic [1:0] FK_UNDER = 2'd1;
    localparam logic [1:0] FK_OVER  = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] byte_count;
        logic        allocator_kind;
        logic [7:0]  target_region;
        logic [31:0] addr;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  new_index;
        logic [31:0] new_start;
        logic [31:0] committed_now;
        logic        hit;
        logic [3:0]  hit_index;
        logic        hit_kind;
        logic [1:0]  fault_kind;
        logic [3:0]  fault_index;
    } out_beat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_EXEC,
        S_SCAN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;      // capture input beat
        logic decide;    // evaluate alloc / expand checks
        logic rd_issue;  // issue memory read (expand: target_region, scan: index)
        logic exec;      // expand update using read data
        logic scan_step; // evaluate one entry of lookup
        logic scan_init;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       scan_last;
        logic       scan_empty;
    } sts_t;

endpackage

// ===== hdl/guarded_region_table_core.sv =====
// Top level of the guarded region table: controller plus datapath.
//
//  channel  ports              payload
//  input    s_valid/s_ready    s_data (grt_pkg::in_beat_t)
//  result   m_valid/m_ready    m_data (grt_pkg::out_beat_t)
//  config   cfg_wr_en          cfg_wr_data (space_size)
//
// Allocate: accept, decide, result. Expand: accept, decide, then one
// registered read of the entry memory, then update and result. Lookup:
// N regions are scanned one entry per cycle over the single memory read
// port. Synchronous active-low reset clears counters and state; the entry
// memory is not cleared. A stalled result holds in the result register;
// no new beat is taken until it leaves. Op 3 is consumed without a
// result.
module guarded_region_table_core #(
    parameter int MAX_ENTRIES = grt_pkg::MaxEntriesDefault,
    parameter int PAGE_SHIFT  = grt_pkg::PageShiftDefault,
    parameter int OFFSET_BITS = grt_pkg::OffsetBitsDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  grt_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output grt_pkg::out_beat_t m_data
);
    grt_pkg::cmd_t cmd;
    grt_pkg::sts_t sts;

    grt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .sts(sts), .cmd(cmd)
    );

    grt_datapath #(
        .MAX_ENTRIES(MAX_ENTRIES), .PAGE_SHIFT(PAGE_SHIFT), .OFFSET_BITS(OFFSET_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_data(s_data), .m_data(m_data),
        .cmd(cmd), .sts(sts)
    );
endmodule

// ===== hdl/grt_ctrl.sv =====
// Controller state machine for the guarded region table.
module grt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  grt_pkg::sts_t sts,
    output grt_pkg::cmd_t cmd
);
    grt_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= grt_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            grt_pkg::S_IDLE: begin
                if (s_valid) state_next = grt_pkg::S_DECIDE;
            end
            grt_pkg::S_DECIDE: begin
                case (sts.op)
                    grt_pkg::OP_ALLOC:  state_next = grt_pkg::S_OUT;
                    grt_pkg::OP_EXPAND: state_next = grt_pkg::S_READ;
                    grt_pkg::OP_LOOKUP: begin
                        // entry 0 is loaded into the read register in this state
                        if (sts.scan_empty) state_next = grt_pkg::S_OUT;
                        else state_next = grt_pkg::S_SCAN;
                    end
                    default: state_next = grt_pkg::S_IDLE;
                endcase
            end
            grt_pkg::S_READ: state_next = grt_pkg::S_EXEC;
            grt_pkg::S_EXEC: state_next = grt_pkg::S_OUT;
            grt_pkg::S_SCAN: begin
                if (sts.scan_last) state_next = grt_pkg::S_OUT;
            end
            grt_pkg::S_OUT: begin
                if (m_ready) state_next = grt_pkg::S_IDLE;
            end
            default: state_next = grt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            grt_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            grt_pkg::S_DECIDE: begin
                cmd.decide    = 1'b1;
                cmd.scan_init = 1'b1;
                cmd.rd_issue  = 1'b1;
            end
            grt_pkg::S_EXEC: cmd.exec = 1'b1;
            grt_pkg::S_SCAN: begin
                cmd.scan_step = 1'b1;
                cmd.rd_issue  = 1'b1;
            end
            grt_pkg::S_OUT: begin
                m_valid = 1'b1;
            end
            default: cmd = '0;
        endcase
    end
endmodule

// ===== hdl/grt_datapath.sv =====
// Datapath: region memory, counters, checks and result register.
module grt_datapath #(
    parameter int MAX_ENTRIES = grt_pkg::MaxEntriesDefault,
    parameter int PAGE_SHIFT  = grt_pkg::PageShiftDefault,
    parameter int OFFSET_BITS = grt_pkg::OffsetBitsDefault
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,
    input  grt_pkg::in_beat_t    s_data,
    output grt_pkg::out_beat_t   m_data,
    input  grt_pkg::cmd_t        cmd,
    output grt_pkg::sts_t        sts
);
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [33:0] PAGE   = 34'd1 << PAGE_SHIFT;
    localparam logic [33:0] OFFMAX = (OFFSET_BITS >= 34) ? {34{1'b1}}
                                   : ((34'd1 << OFFSET_BITS) - 34'd1);

    // entry word: start, capacity, committed, kind
    logic [31:0] mem_start [MAX_ENTRIES];
    logic [31:0] mem_cap   [MAX_ENTRIES];
    logic [31:0] mem_com   [MAX_ENTRIES];
    logic        mem_kind  [MAX_ENTRIES];

    logic [31:0] space_reg;
    logic [CW-1:0] total_reg;
    logic [31:0] free_reg;
    grt_pkg::in_beat_t in_reg;
    grt_pkg::out_beat_t res_reg, res_next;

    logic [31:0] rd_start_reg, rd_cap_reg, rd_com_reg;
    logic        rd_kind_reg;
    logic [CW-1:0] rd_addr_reg, rd_addr_next; // address issued
    logic [CW-1:0] scan_idx_reg;               // entry held in rd_*_reg
    logic          found_reg, faulted_reg;

    logic [33:0] cap_rnd, end_sum, limit;
    logic        wr_en;
    logic [IW-1:0] wr_idx;
    logic [31:0] wr_start, wr_cap, wr_com;
    logic        wr_kind;

    always_comb begin
        cap_rnd = ({2'b0, in_reg.byte_count} + PAGE - 34'd1) & ~(PAGE - 34'd1);
        end_sum = {2'b0, free_reg} + cap_rnd + (PAGE << 1);
        limit   = ({2'b0, space_reg} > OFFMAX) ? OFFMAX : {2'b0, space_reg};
    end

    assign sts.op         = in_reg.op;
    assign sts.scan_empty = (total_reg == '0);
    assign sts.scan_last  = (scan_idx_reg + CW'(1) >= total_reg);
    assign m_data = res_reg;

    always_comb begin
        rd_addr_next = rd_addr_reg;
        if (cmd.rd_issue) begin
            if (cmd.decide) begin
                rd_addr_next = (in_reg.op == grt_pkg::OP_EXPAND)
                             ? CW'(in_reg.target_region[IW-1:0]) : '0;
            end else begin
                rd_addr_next = rd_addr_reg + CW'(1);
            end
        end
    end

    // memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_start[wr_idx] <= wr_start;
            mem_cap[wr_idx]   <= wr_cap;
            mem_com[wr_idx]   <= wr_com;
            mem_kind[wr_idx]  <= wr_kind;
        end
        if (cmd.rd_issue) begin
            rd_start_reg <= mem_start[rd_addr_next[IW-1:0]];
            rd_cap_reg   <= mem_cap[rd_addr_next[IW-1:0]];
            rd_com_reg   <= mem_com[rd_addr_next[IW-1:0]];
            rd_kind_reg  <= mem_kind[rd_addr_next[IW-1:0]];
            scan_idx_reg <= rd_addr_next;
        end
        rd_addr_reg <= rd_addr_next;
        if (cmd.load) in_reg <= s_data;
        res_reg <= res_next;
    end

    logic [33:0] s64, e64, a64, grow, csum;
    logic alloc_ok;
    always_comb begin
        s64  = {2'b0, rd_start_reg};
        e64  = s64 + {2'b0, rd_cap_reg};
        a64  = {2'b0, in_reg.addr};
        grow = ({2'b0, in_reg.byte_count} + PAGE - 34'd1) & ~(PAGE - 34'd1);
        csum = {2'b0, rd_com_reg} + grow;
        alloc_ok = (total_reg < CW'(MAX_ENTRIES)) && !(end_sum > limit)
                 && !(end_sum > 34'hFFFFFFFF);
        wr_en    = 1'b0;
        wr_idx   = total_reg[IW-1:0];
        wr_start = 32'(({2'b0, free_reg} + PAGE));
        wr_cap   = cap_rnd[31:0];
        wr_com   = (cap_rnd < (PAGE << 1)) ? cap_rnd[31:0] : 32'((PAGE << 1));
        wr_kind  = in_reg.allocator_kind;
        if (cmd.decide && in_reg.op == grt_pkg::OP_ALLOC && alloc_ok) begin
            wr_en = 1'b1;
        end else if (cmd.exec && !(csum > {2'b0, rd_cap_reg})
                     && {24'b0, in_reg.target_region} < 32'(total_reg)) begin
            wr_en    = 1'b1;
            wr_idx   = in_reg.target_region[IW-1:0];
            wr_start = rd_start_reg;
            wr_cap   = rd_cap_reg;
            wr_com   = csum[31:0];
            wr_kind  = rd_kind_reg;
        end
    end

    always_comb begin
        res_next = res_reg;
        if (cmd.decide) begin
            res_next = '0;
            if (in_reg.op == grt_pkg::OP_ALLOC) begin
                if (total_reg >= CW'(MAX_ENTRIES)) res_next.status = grt_pkg::ST_FULL;
                else if (!alloc_ok) res_next.status = grt_pkg::ST_NOSPACE;
                else begin
                    res_next.status        = grt_pkg::ST_OK;
                    res_next.new_index     = 4'(total_reg);
                    res_next.new_start     = wr_start;
                    res_next.committed_now = wr_com;
                end
            end
        end
        if (cmd.exec) begin
            if ({24'b0, in_reg.target_region} >= 32'(total_reg)) begin
                res_next.status = grt_pkg::ST_UNKNOWN;
            end else if (csum > {2'b0, rd_cap_reg}) begin
                res_next.status        = grt_pkg::ST_OVERCAP;
                res_next.committed_now = rd_com_reg;
            end else begin
                res_next.status        = grt_pkg::ST_OK;
                res_next.committed_now = csum[31:0];
            end
        end
        if (cmd.scan_step) begin
            if (!found_reg && a64 >= s64 && a64 < e64) begin
                res_next.hit       = 1'b1;
                res_next.hit_index = 4'(scan_idx_reg);
                res_next.hit_kind  = rd_kind_reg;
            end
            if (!faulted_reg) begin
                if (s64 >= PAGE && a64 >= s64 - PAGE && a64 < s64) begin
                    res_next.fault_kind  = grt_pkg::FK_UNDER;
                    res_next.fault_index = 4'(scan_idx_reg);
                end else if (a64 >= e64 && a64 < e64 + PAGE) begin
                    res_next.fault_kind  = grt_pkg::FK_OVER;
                    res_next.fault_index = 4'(scan_idx_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            space_reg   <= grt_pkg::SpaceSizeReset;
            total_reg   <= '0;
            free_reg    <= '0;
            found_reg   <= 1'b0;
            faulted_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) space_reg <= cfg_wr_data;
            if (cmd.decide && in_reg.op == grt_pkg::OP_ALLOC && alloc_ok) begin
                total_reg <= total_reg + CW'(1);
                free_reg  <= end_sum[31:0];
            end
            if (cmd.scan_init) begin
                found_reg   <= 1'b0;
                faulted_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                found_reg   <= res_next.hit;
                faulted_reg <= (res_next.fault_kind != grt_pkg::FK_NONE);
            end
        end
    end
endmodule
